### src/shortest_first_sorted_queue_core_assert.svh
// Assertion macros for the shortest-first sorted queue core.
`ifndef SHORTEST_FIRST_SORTED_QUEUE_CORE_ASSERT_SVH
`define SHORTEST_FIRST_SORTED_QUEUE_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define SFQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define SFQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/sfq_pkg.sv
// Shared types and constants for the shortest-first sorted queue.
package sfq_pkg;

  localparam int SFQ_DEPTH    = 64;
  localparam int SFQ_KEY_BITS = 16;
  localparam int SFQ_TAG_BITS = 16;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } sfq_op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } sfq_status_t;

  typedef struct packed {
    sfq_op_t     op;
    logic [15:0] key_length;
    logic [15:0] msg_tag;
  } sfq_in_t;

  typedef struct packed {
    sfq_status_t status;
    logic        out_valid;
    logic [15:0] out_length;
    logic [15:0] out_tag;
    logic [6:0]  held_count;
  } sfq_out_t;

  // Per-cycle command broadcast to every cell.
  typedef struct packed {
    logic push;
    logic pop;
  } sfq_ctl_t;

endpackage

### src/sfq_cell.sv
// One slot of the sorted chain: holds an entry, compares and shifts.
module sfq_cell import sfq_pkg::*; #(
  parameter int IDX      = 0,
  parameter int CNT_BITS = 7,
  parameter int KEY_BITS = SFQ_KEY_BITS,
  parameter int TAG_BITS = SFQ_TAG_BITS
) (
  input  logic                clk,
  input  sfq_ctl_t            ctl,
  input  logic [CNT_BITS-1:0] count,
  input  logic [KEY_BITS-1:0] new_key,
  input  logic [TAG_BITS-1:0] new_tag,
  input  logic                left_gt,
  input  logic [KEY_BITS-1:0] left_key,
  input  logic [TAG_BITS-1:0] left_tag,
  input  logic [KEY_BITS-1:0] right_key,
  input  logic [TAG_BITS-1:0] right_tag,
  output logic                gt,
  output logic [KEY_BITS-1:0] key,
  output logic [TAG_BITS-1:0] tag
);

  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic [TAG_BITS-1:0] tag_r, tag_nxt;
  logic                occupied;

  assign occupied = count > CNT_BITS'(IDX);
  // Strictly greater, so a new entry lands after equal keys
  assign gt       = occupied && (key_r > new_key);

  always_comb begin
    key_nxt = key_r;
    tag_nxt = tag_r;
    if (ctl.push) begin
      if (left_gt) begin
        key_nxt = left_key;
        tag_nxt = left_tag;
      end else if (gt || !occupied) begin
        key_nxt = new_key;
        tag_nxt = new_tag;
      end
    end else if (ctl.pop) begin
      key_nxt = right_key;
      tag_nxt = right_tag;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    tag_r <= tag_nxt;
  end

  assign key = key_r;
  assign tag = tag_r;

endmodule

### src/shortest_first_sorted_queue_core.sv
// Top level of the shortest-first sorted queue: cell chain, count and result register.
//
//   channel | ports                      | transfer when
//   --------+----------------------------+-----------------------
//   input   | start, busy, in_data       | start && !busy
//   result  | out_strobe, out_data       | out_strobe (one cycle)
//
// One item per cycle: every cell compares the broadcast key and shifts in the
// same cycle, so busy stays low. The result appears in the cycle after the
// transfer, for one cycle. Synchronous reset clears the count and the strobe;
// the cell contents are not cleared, only slots below the count are read.
// The receiver cannot stall.
module shortest_first_sorted_queue_core import sfq_pkg::*; #(
  parameter int DEPTH    = SFQ_DEPTH,
  parameter int KEY_BITS = SFQ_KEY_BITS,
  parameter int TAG_BITS = SFQ_TAG_BITS
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  sfq_in_t  in_data,
  output logic     out_strobe,
  output sfq_out_t out_data
);

  localparam int CNT_BITS = $clog2(DEPTH + 1);

  logic [CNT_BITS-1:0] count_r, count_nxt;
  logic                strobe_r;
  sfq_out_t            out_r, out_nxt;
  logic                accept, is_full, is_empty;
  sfq_ctl_t            ctl;
  logic [KEY_BITS-1:0] new_key;
  logic [TAG_BITS-1:0] new_tag;

  logic [KEY_BITS-1:0] cell_key [DEPTH];
  logic [TAG_BITS-1:0] cell_tag [DEPTH];
  logic                cell_gt  [DEPTH];

  assign busy     = 1'b0;
  assign accept   = start && !busy;
  assign is_full  = count_r == CNT_BITS'(DEPTH);
  assign is_empty = count_r == '0;
  assign new_key  = KEY_BITS'(in_data.key_length);
  assign new_tag  = TAG_BITS'(in_data.msg_tag);

  assign ctl.push = accept && (in_data.op == OP_PUSH) && !is_full;
  assign ctl.pop  = accept && (in_data.op == OP_POP) && !is_empty;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                lgt;
    logic [KEY_BITS-1:0] lkey, rkey;
    logic [TAG_BITS-1:0] ltag, rtag;

    if (i == 0) begin : g_head
      assign lgt  = 1'b0;
      assign lkey = '0;
      assign ltag = '0;
    end else begin : g_mid
      assign lgt  = cell_gt[i-1];
      assign lkey = cell_key[i-1];
      assign ltag = cell_tag[i-1];
    end

    // Tail refills from itself; that slot is beyond the count after a pop
    if (i == DEPTH - 1) begin : g_tail
      assign rkey = cell_key[i];
      assign rtag = cell_tag[i];
    end else begin : g_body
      assign rkey = cell_key[i+1];
      assign rtag = cell_tag[i+1];
    end

    sfq_cell #(
      .IDX      (i),
      .CNT_BITS (CNT_BITS),
      .KEY_BITS (KEY_BITS),
      .TAG_BITS (TAG_BITS)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .count     (count_r),
      .new_key   (new_key),
      .new_tag   (new_tag),
      .left_gt   (lgt),
      .left_key  (lkey),
      .left_tag  (ltag),
      .right_key (rkey),
      .right_tag (rtag),
      .gt        (cell_gt[i]),
      .key       (cell_key[i]),
      .tag       (cell_tag[i])
    );
  end

  always_comb begin
    count_nxt          = count_r;
    out_nxt.status     = ST_OK;
    out_nxt.out_valid  = 1'b0;
    out_nxt.out_length = '0;
    out_nxt.out_tag    = '0;
    if (ctl.push) begin
      count_nxt = count_r + CNT_BITS'(1);
    end else if (ctl.pop) begin
      count_nxt          = count_r - CNT_BITS'(1);
      out_nxt.out_valid  = 1'b1;
      out_nxt.out_length = 16'(cell_key[0]);
      out_nxt.out_tag    = 16'(cell_tag[0]);
    end else if (accept && in_data.op == OP_PUSH) begin
      out_nxt.status = ST_FULL;
    end else if (accept) begin
      out_nxt.status = ST_EMPTY;
    end
    out_nxt.held_count = 7'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      strobe_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_strobe = strobe_r;
  assign out_data   = out_r;

`include "shortest_first_sorted_queue_core_assert.svh"

  `SFQ_ASSERT_NEXT(a_result_follows, accept, out_strobe, "transfer without result")
  `SFQ_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CNT_BITS'(DEPTH), "count above depth")
  `SFQ_ASSERT_NOW(a_full_flag, out_strobe && out_data.status == ST_FULL, is_full, "full flag while not full")
  `SFQ_ASSERT_NEXT(a_push_grows, ctl.push, count_r == $past(count_r) + CNT_BITS'(1), "push did not grow count")

endmodule

### test/shortest_first_sorted_queue_core_tb.sv
// Self-checking testbench for the shortest-first sorted queue core.
module shortest_first_sorted_queue_core_tb;
  import sfq_pkg::*;

  localparam int IDLE_LIMIT  = 1000;
  localparam int ITEM_TARGET = 1450;

  // Sorted store that mirrors the block and the replies it owes.
  class sjf_queue_model;
    logic [SFQ_KEY_BITS-1:0] held_key [SFQ_DEPTH];
    logic [SFQ_TAG_BITS-1:0] held_tag [SFQ_DEPTH];
    int held;
    int errors;
    sfq_out_t expected_replies [$];

    function new();
      held   = 0;
      errors = 0;
    endfunction

    function int pending();
      return expected_replies.size();
    endfunction

    function void note_request(sfq_in_t req);
      sfq_out_t reply;
      int pos;
      reply = '0;
      reply.status = ST_OK;
      if (req.op == OP_PUSH) begin
        if (held >= SFQ_DEPTH) begin
          reply.status = ST_FULL;
        end else begin
          // shift strictly larger keys up; equal keys stay ahead of the newcomer
          pos = held;
          while (pos > 0 && held_key[pos-1] > req.key_length) begin
            held_key[pos] = held_key[pos-1];
            held_tag[pos] = held_tag[pos-1];
            pos--;
          end
          held_key[pos] = req.key_length;
          held_tag[pos] = req.msg_tag;
          held++;
        end
      end else if (held == 0) begin
        reply.status = ST_EMPTY;
      end else begin
        reply.out_valid  = 1'b1;
        reply.out_length = held_key[0];
        reply.out_tag    = held_tag[0];
        for (pos = 1; pos < held; pos++) begin
          held_key[pos-1] = held_key[pos];
          held_tag[pos-1] = held_tag[pos];
        end
        held--;
      end
      reply.held_count = 7'(held);
      expected_replies.push_back(reply);
    endfunction

    function void check_reply(sfq_out_t got);
      sfq_out_t want;
      if (expected_replies.size() == 0) begin
        $error("unexpected result: status %0d held_count %0d", got.status, got.held_count);
        errors++;
        return;
      end
      want = expected_replies.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.out_valid !== want.out_valid) begin
        $error("out_valid: expected %0d, got %0d", want.out_valid, got.out_valid);
        errors++;
      end
      if (got.out_length !== want.out_length) begin
        $error("out_length: expected %0h, got %0h", want.out_length, got.out_length);
        errors++;
      end
      if (got.out_tag !== want.out_tag) begin
        $error("out_tag: expected %0h, got %0h", want.out_tag, got.out_tag);
        errors++;
      end
      if (got.held_count !== want.held_count) begin
        $error("held_count: expected %0d, got %0d", want.held_count, got.held_count);
        errors++;
      end
    endfunction
  endclass

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  sfq_in_t  in_data;
  logic     out_strobe;
  sfq_out_t out_data;

  sjf_queue_model queue_model = new();
  int unsigned items_sent;
  int unsigned burst_left;
  int unsigned quiet_cycles;

  shortest_first_sorted_queue_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Sample both channels on the rising edge; abort if nothing moves for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_strobe) queue_model.check_reply(out_data);
      if (start && !busy) queue_model.note_request(in_data);
      if (out_strobe || (start && !busy)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("FAIL shortest_first_sorted_queue_core");
        $finish;
      end
    end
  end

  function automatic logic [SFQ_KEY_BITS-1:0] pick_key();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return '1;
      2:       return SFQ_KEY_BITS'($urandom_range(0, 7));
      default: return SFQ_KEY_BITS'($urandom);
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic transfer_item(sfq_in_t item);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      repeat (gap) begin
        start <= 1'b0;
        @(negedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    start   <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (busy);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic push_entry(logic [SFQ_KEY_BITS-1:0] key, logic [SFQ_TAG_BITS-1:0] tag);
    sfq_in_t item;
    item.op         = OP_PUSH;
    item.key_length = key;
    item.msg_tag    = tag;
    transfer_item(item);
  endtask

  task automatic pop_entry();
    sfq_in_t item;
    // key and tag are don't-care on a pop; drive noise there
    item.op         = OP_POP;
    item.key_length = 16'($urandom);
    item.msg_tag    = 16'($urandom);
    transfer_item(item);
  endtask

  // Hold off the sender until every owed reply has arrived.
  task automatic wait_for_results();
    start <= 1'b0;
    do @(negedge clk); while (queue_model.pending() != 0);
  endtask

  initial begin
    int unsigned n;
    rst_n        = 1'b0;
    start        = 1'b0;
    in_data      = '0;
    items_sent   = 0;
    burst_left   = 0;
    quiet_cycles = 0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty pop, extremes, equal keys leaving in arrival order
    pop_entry();
    push_entry(16'hFFFF, 16'h0001);
    push_entry(16'h0000, 16'hFFFF);
    push_entry(16'd100, 16'h000A);
    push_entry(16'd100, 16'h000B);
    push_entry(16'd100, 16'h000C);
    push_entry(16'd50, 16'h000D);
    push_entry(16'hFFFF, 16'h0002);
    repeat (7) pop_entry();
    pop_entry();
    push_entry(16'd7, 16'h0007);
    wait_for_results();

    while (items_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 4))
        0, 1: begin
          n = $urandom_range(20, 60);
          repeat (n) begin
            if ($urandom_range(0, 1)) push_entry(pick_key(), 16'($urandom));
            else pop_entry();
          end
        end
        2: begin
          // fill to the brim, then push into a full queue
          while (queue_model.held < SFQ_DEPTH) push_entry(pick_key(), 16'($urandom));
          repeat ($urandom_range(1, 3)) push_entry(pick_key(), 16'($urandom));
        end
        3: begin
          while (queue_model.held > 0) pop_entry();
          repeat ($urandom_range(1, 3)) pop_entry();
        end
        default: begin
          // narrow key range to pile up ties
          n = $urandom_range(20, 60);
          repeat (n) begin
            if ($urandom_range(0, 2) != 0)
              push_entry(SFQ_KEY_BITS'($urandom_range(0, 3)), 16'($urandom));
            else
              pop_entry();
          end
        end
      endcase
      if ($urandom_range(0, 5) == 0) wait_for_results();
    end

    wait_for_results();
    repeat (4) @(negedge clk);
    if (queue_model.errors == 0 && queue_model.pending() == 0) begin
      $display("PASS shortest_first_sorted_queue_core");
    end else begin
      $display("FAIL shortest_first_sorted_queue_core");
    end
    $finish;
  end

endmodule
